// ===== rtl/core/csis_pkg.sv =====
// Shared constants, codes and types of the closest sorted index search block.
// No dependencies; every other file of the block refers to this package.
package csis_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned PHASE_W     = 2;

  // Item modes; the fourth code is ignored.
  localparam logic [MODE_W-1:0] MODE_APPEND = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_QUERY  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(2);

  // Meaning of the read data a search cell receives.
  localparam logic [PHASE_W-1:0] PH_EXP  = PHASE_W'(0);  // probe for upper bound
  localparam logic [PHASE_W-1:0] PH_BIN  = PHASE_W'(1);  // binary search midpoint
  localparam logic [PHASE_W-1:0] PH_FINA = PHASE_W'(2);  // entry below candidate
  localparam logic [PHASE_W-1:0] PH_FINB = PHASE_W'(3);  // candidate entry

  // Status one search cell (or the whole chain) reports per cycle.
  typedef struct packed {
    logic issue;  // a table read is requested this cycle
    logic done;   // the search finished this cycle
  } step_t;

endpackage

// ===== rtl/core/csis_item_if.sv =====
// Input channel of the closest sorted index search block: valid/ready plus item payload.
// Depends on csis_pkg for field widths.
interface csis_item_if;
  logic                                valid;
  logic                                ready;
  logic [csis_pkg::MODE_W-1:0]         mode;
  logic signed [csis_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/core/csis_result_if.sv =====
// Result channel of the closest sorted index search block: valid/ready plus result payload.
// Depends on csis_pkg for field widths.
interface csis_result_if;
  logic                         valid;
  logic                         ready;
  logic [csis_pkg::INDEX_W-1:0] closest_index;
  logic                         table_empty;

  modport source (output valid, output closest_index, output table_empty, input ready);
  modport sink   (input valid, input closest_index, input table_empty, output ready);
endinterface

// ===== rtl/core/csis_cell.sv =====
// One search cell: holds the search state for one table read and hands the next state on.
// Depends on csis_pkg (phase codes, step_t).
module csis_cell #(
  parameter int unsigned AW = 10,
  parameter int unsigned CW = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [csis_pkg::VALUE_W-1:0] tgt_i,
  input  logic [CW-1:0]                       cnt_i,
  input  logic signed [csis_pkg::VALUE_W-1:0] rd_data_i,
  input  logic                                in_valid_i,
  input  logic [csis_pkg::PHASE_W-1:0]        in_phase_i,
  input  logic [AW-1:0]                       in_lo_i,
  input  logic [AW-1:0]                       in_hi_i,
  input  logic [AW:0]                         in_ptr_i,
  input  logic signed [csis_pkg::VALUE_W:0]   in_below_i,
  output logic                                nxt_valid_o,
  output logic [csis_pkg::PHASE_W-1:0]        nxt_phase_o,
  output logic [AW-1:0]                       nxt_lo_o,
  output logic [AW-1:0]                       nxt_hi_o,
  output logic [AW:0]                         nxt_ptr_o,
  output logic signed [csis_pkg::VALUE_W:0]   nxt_below_o,
  output csis_pkg::step_t                     step_o,
  output logic [AW-1:0]                       rd_addr_o,
  output logic [AW-1:0]                       idx_o
);

  localparam int unsigned PW = AW + 1;
  localparam int unsigned DW = csis_pkg::VALUE_W + 1;

  logic                              valid_q;
  logic [csis_pkg::PHASE_W-1:0]      phase_q;
  logic [AW-1:0]                     lo_q;
  logic [AW-1:0]                     hi_q;
  logic [PW-1:0]                     ptr_q;
  logic signed [DW-1:0]              below_q;

  logic                              rd_lt;
  logic [PW-1:0]                     dbl;
  logic [AW-1:0]                     last;
  logic signed [DW-1:0]              below_w;
  logic signed [DW-1:0]              above_w;
  logic                              use_cont;
  logic [AW-1:0]                     c_lo;
  logic [AW-1:0]                     c_hi;
  logic [PW-1:0]                     mid;
  logic                              done;
  logic [AW-1:0]                     idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= in_phase_i;
    lo_q    <= in_lo_i;
    hi_q    <= in_hi_i;
    ptr_q   <= in_ptr_i;
    below_q <= in_below_i;
  end

  always_comb begin
    rd_lt   = rd_data_i < tgt_i;
    dbl     = {ptr_q[AW-1:0], 1'b0};
    last    = AW'(cnt_i - CW'(1));
    below_w = {tgt_i[csis_pkg::VALUE_W-1], tgt_i}
            - {rd_data_i[csis_pkg::VALUE_W-1], rd_data_i};
    above_w = {rd_data_i[csis_pkg::VALUE_W-1], rd_data_i}
            - {tgt_i[csis_pkg::VALUE_W-1], tgt_i};

    nxt_valid_o = 1'b0;
    nxt_phase_o = phase_q;
    nxt_lo_o    = lo_q;
    nxt_hi_o    = hi_q;
    nxt_ptr_o   = ptr_q;
    nxt_below_o = below_q;
    use_cont    = 1'b0;
    c_lo        = lo_q;
    c_hi        = hi_q;
    done        = 1'b0;
    idx         = '0;

    case (phase_q)
      csis_pkg::PH_EXP: begin
        if (rd_lt && (dbl < PW'(cnt_i))) begin
          nxt_valid_o = valid_q;
          nxt_phase_o = csis_pkg::PH_EXP;
          nxt_ptr_o   = dbl;
        end else begin
          // Bound found: either the probe or the last entry.
          use_cont = 1'b1;
          c_hi     = rd_lt ? last : ptr_q[AW-1:0];
          c_lo     = c_hi >> 1;
        end
      end
      csis_pkg::PH_BIN: begin
        use_cont = 1'b1;
        if (rd_lt) begin
          c_lo = ptr_q[AW-1:0] + AW'(1);
          c_hi = hi_q;
        end else begin
          c_lo = lo_q;
          c_hi = ptr_q[AW-1:0];
        end
      end
      csis_pkg::PH_FINA: begin
        nxt_valid_o = valid_q;
        nxt_phase_o = csis_pkg::PH_FINB;
        nxt_ptr_o   = {1'b0, lo_q};
        nxt_below_o = below_w;
      end
      csis_pkg::PH_FINB: begin
        // Tie goes to the lower index.
        done = valid_q;
        idx  = (below_q <= above_w) ? lo_q - AW'(1) : lo_q;
      end
      default: begin
        done = 1'b0;
      end
    endcase

    mid = ({1'b0, c_lo} + {1'b0, c_hi}) >> 1;

    if (use_cont) begin
      if (c_lo < c_hi) begin
        nxt_valid_o = valid_q;
        nxt_phase_o = csis_pkg::PH_BIN;
        nxt_lo_o    = c_lo;
        nxt_hi_o    = c_hi;
        nxt_ptr_o   = mid;
      end else if (c_lo == '0) begin
        done = valid_q;
        idx  = '0;
      end else begin
        nxt_valid_o = valid_q;
        nxt_phase_o = csis_pkg::PH_FINA;
        nxt_lo_o    = c_lo;
        nxt_ptr_o   = {1'b0, c_lo - AW'(1)};
      end
    end
  end

  assign step_o.issue = nxt_valid_o;
  assign step_o.done  = done;
  assign rd_addr_o    = nxt_valid_o ? nxt_ptr_o[AW-1:0] : '0;
  assign idx_o        = done ? idx : '0;

endmodule

// ===== rtl/core/csis_chain.sv =====
// Row of search cells; the search state moves one cell per table read.
// Depends on csis_pkg and csis_cell.
module csis_chain #(
  parameter int unsigned AW = 10,
  parameter int unsigned CW = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [csis_pkg::VALUE_W-1:0] tgt_i,
  input  logic [CW-1:0]                       cnt_i,
  input  logic signed [csis_pkg::VALUE_W-1:0] rd_data_i,
  output csis_pkg::step_t                     step_o,
  output logic [AW-1:0]                       rd_addr_o,
  output logic [AW-1:0]                       idx_o,
  output logic                                lost_o
);

  // Upper-bound probes, binary steps and two final reads.
  localparam int unsigned NCELL = 2 * AW + 2;
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned DW    = csis_pkg::VALUE_W + 1;

  logic                         hv    [0:NCELL];
  logic [csis_pkg::PHASE_W-1:0] hph   [0:NCELL];
  logic [AW-1:0]                hlo   [0:NCELL];
  logic [AW-1:0]                hhi   [0:NCELL];
  logic [PW-1:0]                hptr  [0:NCELL];
  logic signed [DW-1:0]         hbel  [0:NCELL];
  csis_pkg::step_t              st    [0:NCELL-1];
  logic [AW-1:0]                caddr [0:NCELL-1];
  logic [AW-1:0]                cidx  [0:NCELL-1];

  // First cell receives the probe of entry one.
  assign hv[0]   = start_i;
  assign hph[0]  = csis_pkg::PH_EXP;
  assign hlo[0]  = '0;
  assign hhi[0]  = '0;
  assign hptr[0] = PW'(1);
  assign hbel[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    csis_cell #(
      .AW (AW),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tgt_i       (tgt_i),
      .cnt_i       (cnt_i),
      .rd_data_i   (rd_data_i),
      .in_valid_i  (hv[k]),
      .in_phase_i  (hph[k]),
      .in_lo_i     (hlo[k]),
      .in_hi_i     (hhi[k]),
      .in_ptr_i    (hptr[k]),
      .in_below_i  (hbel[k]),
      .nxt_valid_o (hv[k+1]),
      .nxt_phase_o (hph[k+1]),
      .nxt_lo_o    (hlo[k+1]),
      .nxt_hi_o    (hhi[k+1]),
      .nxt_ptr_o   (hptr[k+1]),
      .nxt_below_o (hbel[k+1]),
      .step_o      (st[k]),
      .rd_addr_o   (caddr[k]),
      .idx_o       (cidx[k])
    );
  end

  // At most one cell is active; its outputs are the only nonzero ones.
  always_comb begin
    step_o    = '0;
    rd_addr_o = '0;
    idx_o     = '0;
    for (int k = 0; k < NCELL; k++) begin
      step_o.issue = step_o.issue | st[k].issue;
      step_o.done  = step_o.done | st[k].done;
      rd_addr_o    = rd_addr_o | caddr[k];
      idx_o        = idx_o | cidx[k];
    end
  end

  // State pushed out of the last cell would be a lost search.
  assign lost_o = hv[NCELL];

endmodule

// ===== rtl/core/closest_sorted_index_search_top.sv =====
// Top level of the closest sorted index search block: table memory, control, result buffer.
// Depends on csis_pkg, csis_item_if, csis_result_if and csis_chain.
//
// The block keeps a table of up to TABLE_DEPTH signed 32-bit values, meant to be appended in
// ascending order, and answers queries with the lowest index of the entry nearest the target
// (the lower index on a tie). Each input transaction appends its value (dropped when the
// table is full), clears the table, or queries; the unused mode code is ignored. Only a
// query yields a result transaction; on an empty table it answers index 0 with table_empty
// set. Table contents are not checked for order: an unsorted table gets the answer of the
// same probe sequence. Append and clear act when accepted, and a query on a table of zero or
// one entry is answered without a search. Any other query runs an exponential search for an
// upper bound and then a binary search, one table read per cycle through the single read
// port of the table memory: at most 2*log2(TABLE_DEPTH)+2 reads, which is 22 reads for 1024
// entries, and one item is searched at a time. A result that waits on the output is held in
// a two-deep buffer, so the block keeps taking appends and clears; a new item is refused only
// while a search runs or both buffer slots are full. The table needs no clearing pass after
// reset.
module closest_sorted_index_search_top #(
  parameter int unsigned TABLE_DEPTH = csis_pkg::TABLE_DEPTH
) (
  input logic           clk_i,
  input logic           rst_ni,
  csis_item_if.sink     item_i,
  csis_result_if.source result_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = AW + csis_pkg::INDEX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                                state_q;
  logic                                state_d;
  logic [CW-1:0]                       cnt_q;
  logic [CW-1:0]                       cnt_d;
  logic signed [csis_pkg::VALUE_W-1:0] tgt_q;
  logic [csis_pkg::VALUE_W-1:0]        mem_q [0:TABLE_DEPTH-1];
  logic signed [csis_pkg::VALUE_W-1:0] rd_q;

  logic                                accept;
  logic                                is_append;
  logic                                is_query;
  logic                                is_clear;
  logic                                full;
  logic                                wr_en;
  logic                                start;
  logic                                quick;
  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;

  csis_pkg::step_t                     step;
  logic [AW-1:0]                       chain_addr;
  logic [AW-1:0]                       chain_idx;
  logic                                chain_lost;

  logic                                res_new;
  logic [EW-1:0]                       idx_ext;
  logic [csis_pkg::INDEX_W-1:0]        res_idx;
  logic                                res_empty;
  logic                                out_free;

  logic                                out_valid_q;
  logic                                out_valid_d;
  logic [csis_pkg::INDEX_W-1:0]        out_idx_q;
  logic                                out_empty_q;
  logic                                pend_valid_q;
  logic                                pend_valid_d;
  logic [csis_pkg::INDEX_W-1:0]        pend_idx_q;
  logic                                pend_empty_q;

  // ---------------------------------------------------------------- input decode
  assign item_i.ready = (state_q == ST_IDLE) && !pend_valid_q;
  assign accept       = item_i.valid && item_i.ready;
  assign is_append    = accept && (item_i.mode == csis_pkg::MODE_APPEND);
  assign is_query     = accept && (item_i.mode == csis_pkg::MODE_QUERY);
  assign is_clear     = accept && (item_i.mode == csis_pkg::MODE_CLEAR);

  assign full  = cnt_q == CW'(TABLE_DEPTH);
  assign wr_en = is_append && !full;
  // Tables of zero or one entry are answered at once; larger ones start a search.
  assign quick = is_query && (cnt_q <= CW'(1));
  assign start = is_query && (cnt_q > CW'(1));

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (is_clear) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (step.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the target for the whole search.
  always_ff @(posedge clk_i) begin
    if (start) begin
      tgt_q <= item_i.value;
    end
  end

  // ---------------------------------------------------------------- table memory
  // Writes come only from appends while idle, reads only from a search: never together.
  assign rd_en   = start || step.issue;
  assign rd_addr = start ? AW'(1) : chain_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // ---------------------------------------------------------------- search chain
  csis_chain #(
    .AW (AW),
    .CW (CW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .tgt_i     (tgt_q),
    .cnt_i     (cnt_q),
    .rd_data_i (rd_q),
    .step_o    (step),
    .rd_addr_o (chain_addr),
    .idx_o     (chain_idx),
    .lost_o    (chain_lost)
  );

  // ---------------------------------------------------------------- result buffer
  // Chain index is zero unless the chain finished, which matches the quick answer.
  assign res_new   = quick || step.done;
  assign idx_ext   = EW'(chain_idx);
  assign res_idx   = idx_ext[csis_pkg::INDEX_W-1:0];
  assign res_empty = quick && (cnt_q == '0);
  assign out_free  = !out_valid_q || result_o.ready;

  // The pending slot fills only when a result arrives while the output stalls.
  assign out_valid_d  = pend_valid_q || res_new || (out_valid_q && !result_o.ready);
  assign pend_valid_d = pend_valid_q ? !out_free : (res_new && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_idx_q   <= pend_idx_q;
        out_empty_q <= pend_empty_q;
      end else if (res_new) begin
        out_idx_q   <= res_idx;
        out_empty_q <= res_empty;
      end
    end else if (res_new) begin
      pend_idx_q   <= res_idx;
      pend_empty_q <= res_empty;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.closest_index = out_idx_q;
  assign result_o.table_empty   = out_empty_q;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.done |-> state_q == ST_BUSY)
    else $error("search finished outside a search");

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending result without an output result");

  a_cnt_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUSY |=> $stable(cnt_q))
    else $error("entry count changed during a search");

  a_chain_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUSY |-> !chain_lost)
    else $error("search ran past the last cell");
`endif

endmodule
